// ===== design/y86dec_pkg.sv =====
// Shared types, instruction codes and helpers for the Y86-64 instruction decoder.
`timescale 1ns / 1ps
`default_nettype none

package y86dec_pkg;

    // Instruction codes (high nibble of the first byte)
    localparam logic [3:0] OP_HALT   = 4'd0;
    localparam logic [3:0] OP_NOP    = 4'd1;
    localparam logic [3:0] OP_CMOVXX = 4'd2;
    localparam logic [3:0] OP_IRMOVQ = 4'd3;
    localparam logic [3:0] OP_RMMOVQ = 4'd4;
    localparam logic [3:0] OP_MRMOVQ = 4'd5;
    localparam logic [3:0] OP_OPQ    = 4'd6;
    localparam logic [3:0] OP_JXX    = 4'd7;
    localparam logic [3:0] OP_CALL   = 4'd8;
    localparam logic [3:0] OP_RET    = 4'd9;
    localparam logic [3:0] OP_PUSHQ  = 4'd10;
    localparam logic [3:0] OP_POPQ   = 4'd11;

    // Limits on fields
    localparam logic [3:0] CODE_MAX   = 4'd11;
    localparam logic [3:0] FN_MAX_ALU = 4'd6;
    localparam logic [3:0] REG_MAX    = 4'd14;
    localparam logic [3:0] REG_NONE   = 4'd15;

    // Lengths of data items
    localparam logic [3:0] QUAD_LEN = 4'd8;
    localparam logic [3:0] BYTE_LEN = 4'd1;

    // Kind of decoded item
    typedef enum logic [1:0] {
        KIND_INSTR = 2'd0,
        KIND_QUAD  = 2'd1,
        KIND_BYTE  = 2'd2
    } item_kind_t;

    // One decoded result
    typedef struct packed {
        item_kind_t  kind;
        logic [3:0]  code;
        logic [3:0]  fn;
        logic [3:0]  ra;
        logic [3:0]  rb;
        logic [63:0] cval;
        logic [3:0]  clen;
    } decode_result_t;

    // Encoded length of an instruction by its code
    function automatic logic [3:0] instr_len(input logic [3:0] code);
        logic [3:0] len;
        begin
            case (code)
                OP_HALT, OP_NOP, OP_RET:              len = 4'd1;
                OP_CMOVXX, OP_OPQ, OP_PUSHQ, OP_POPQ: len = 4'd2;
                OP_JXX, OP_CALL:                      len = 4'd9;
                default:                              len = 4'd10;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/y86dec_decode.sv =====
// Combinational decode of one Y86-64 instruction or data item from a byte window.
`timescale 1ns / 1ps
`default_nettype none

module y86dec_decode (
    input  wire logic [63:0]              window_low,
    input  wire logic [15:0]              window_high,
    input  wire logic [3:0]               bytes_available,
    input  wire logic [2:0]               address_low,
    output y86dec_pkg::decode_result_t    result
);

    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [3:0] code;
    logic [3:0] fn;
    logic [3:0] ra;
    logic [3:0] rb;
    logic [3:0] len;
    logic       fn_ok;
    logic       reg_ok;
    logic       valid;

    // Split the leading bytes into nibbles
    assign byte0 = window_low[7:0];
    assign byte1 = window_low[15:8];
    assign code  = byte0[7:4];
    assign fn    = byte0[3:0];
    assign ra    = byte1[7:4];
    assign rb    = byte1[3:0];
    assign len   = y86dec_pkg::instr_len(code);

    // Check the function nibble against the code
    always_comb
    begin
        if (code inside {y86dec_pkg::OP_CMOVXX, y86dec_pkg::OP_OPQ, y86dec_pkg::OP_JXX})
        begin
            fn_ok = (fn <= y86dec_pkg::FN_MAX_ALU);
        end
        else
        begin
            fn_ok = (fn == 4'd0);
        end
    end

    // Check the register byte rules
    always_comb
    begin
        case (code)
            y86dec_pkg::OP_CMOVXX, y86dec_pkg::OP_RMMOVQ,
            y86dec_pkg::OP_MRMOVQ, y86dec_pkg::OP_OPQ:
                reg_ok = (ra <= y86dec_pkg::REG_MAX) && (rb <= y86dec_pkg::REG_MAX);
            y86dec_pkg::OP_IRMOVQ:
                reg_ok = (ra == y86dec_pkg::REG_NONE);
            y86dec_pkg::OP_PUSHQ, y86dec_pkg::OP_POPQ:
                reg_ok = (ra <= y86dec_pkg::REG_MAX) && (rb == y86dec_pkg::REG_NONE);
            default:
                reg_ok = 1'b1;
        endcase
    end

    assign valid = (code <= y86dec_pkg::CODE_MAX) && fn_ok && reg_ok
                   && (bytes_available >= len);

    // Select the result fields
    always_comb
    begin
        result.code = code;
        result.fn   = fn;
        result.ra   = y86dec_pkg::REG_NONE;
        result.rb   = y86dec_pkg::REG_NONE;
        result.cval = 64'd0;
        if (valid)
        begin
            result.kind = y86dec_pkg::KIND_INSTR;
            result.clen = len;
            if (code inside {y86dec_pkg::OP_CMOVXX, [y86dec_pkg::OP_IRMOVQ : y86dec_pkg::OP_OPQ],
                             y86dec_pkg::OP_PUSHQ, y86dec_pkg::OP_POPQ})
            begin
                result.ra = ra;
                result.rb = rb;
            end
            if (code inside {[y86dec_pkg::OP_IRMOVQ : y86dec_pkg::OP_MRMOVQ]})
            begin
                result.cval = {window_high, window_low[63:16]};
            end
            else if (code inside {y86dec_pkg::OP_JXX, y86dec_pkg::OP_CALL})
            begin
                result.cval = {window_high[7:0], window_low[63:8]};
            end
        end
        else if ((address_low == 3'd0) && (bytes_available >= y86dec_pkg::QUAD_LEN))
        begin
            result.kind = y86dec_pkg::KIND_QUAD;
            result.clen = y86dec_pkg::QUAD_LEN;
            result.cval = window_low;
        end
        else
        begin
            result.kind = y86dec_pkg::KIND_BYTE;
            result.clen = y86dec_pkg::BYTE_LEN;
            result.cval = {56'd0, byte0};
        end
    end

endmodule

`default_nettype wire

// ===== design/y86_instruction_decoder_core.sv =====
// Top level of the Y86-64 instruction decoder: input register, decode, result register.
//
// Decodes one Y86-64 instruction (or a data quad / data byte when the bytes do
// not form a valid instruction) per transaction. A transaction is taken on any
// cycle with start high; busy is never raised, so one transaction per clock is
// sustained. Each transaction passes through the input register and then the
// result register, which bracket the single pass of decode logic. The result
// is then shown on the result ports and flagged by done, which is high for
// one cycle per result, and the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none

module y86_instruction_decoder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] window_low,
    input  wire logic [15:0] window_high,
    input  wire logic [3:0]  bytes_available,
    input  wire logic [2:0]  address_low,
    output logic             done,
    output logic [1:0]       item_kind,
    output logic [3:0]       instr_code,
    output logic [3:0]       instr_function,
    output logic [3:0]       reg_a,
    output logic [3:0]       reg_b,
    output logic [63:0]      constant_value,
    output logic [3:0]       consumed_length
);

    logic                       in_valid_reg;
    logic [63:0]                window_low_reg;
    logic [15:0]                window_high_reg;
    logic [3:0]                 avail_reg;
    logic [2:0]                 addr_reg;
    logic                       done_reg;
    y86dec_pkg::decode_result_t result_reg;
    y86dec_pkg::decode_result_t result_next;

    // Never hold off a transaction
    assign busy = 1'b0;

    // Capture the incoming transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            window_low_reg  <= window_low;
            window_high_reg <= window_high;
            avail_reg       <= bytes_available;
            addr_reg        <= address_low;
        end
    end

    // Decode the held window
    y86dec_decode u_decode (
        .window_low      (window_low_reg),
        .window_high     (window_high_reg),
        .bytes_available (avail_reg),
        .address_low     (addr_reg),
        .result          (result_next)
    );

    // Advance the decoded result to the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    // Drive the result ports
    assign done            = done_reg;
    assign item_kind       = result_reg.kind;
    assign instr_code      = result_reg.code;
    assign instr_function  = result_reg.fn;
    assign reg_a           = result_reg.ra;
    assign reg_b           = result_reg.rb;
    assign constant_value  = result_reg.cval;
    assign consumed_length = result_reg.clen;

endmodule

`default_nettype wire
